### rtl/fmms_pkg.sv
// Shared types and constants for the frame store with min/max stretch.
`timescale 1ns / 1ps

package fmms_pkg;

   localparam int DEF_MAX_COLS  = 64;
   localparam int DEF_MAX_ROWS  = 64;
   localparam int DEF_CELL_BITS = 16;

   // Address field wide enough for the largest store (127 x 127 cells).
   localparam int ADDR_BITS   = 14;
   localparam int VALUE_BITS  = 16;
   localparam int QUEUE_DEPTH = 2;

   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_READ  = 1'b1;

   localparam logic [2:0] REG_COLS_IN_USE   = 3'd0;
   localparam logic [2:0] REG_ROWS_IN_USE   = 3'd1;
   localparam logic [2:0] REG_OUT_MIN       = 3'd2;
   localparam logic [2:0] REG_OUT_MAX       = 3'd3;
   localparam logic [2:0] REG_OUTSIDE_VALUE = 3'd4;

   localparam logic [6:0]         RST_COLS_IN_USE   = 7'd64;
   localparam logic [6:0]         RST_ROWS_IN_USE   = 7'd64;
   localparam logic signed [15:0] RST_OUT_MIN       = 16'sd0;
   localparam logic signed [15:0] RST_OUT_MAX       = 16'sd255;
   localparam logic signed [15:0] RST_OUTSIDE_VALUE = 16'sd0;

   typedef enum logic [1:0] {
      OP_WRITE,
      OP_WRITE_SKIP,
      OP_READ,
      OP_READ_SKIP
   } op_kind_type;

   typedef struct packed {
      op_kind_type              kind;
      logic [ADDR_BITS-1:0]     addr;
      logic signed [VALUE_BITS-1:0] value;
   } op_type;

   typedef struct packed {
      logic [6:0]         cols_in_use;
      logic [6:0]         rows_in_use;
      logic signed [15:0] out_min;
      logic signed [15:0] out_max;
      logic signed [15:0] outside_value;
   } cfg_type;

endpackage

### rtl/fmms_front.sv
// Front end: accepts items, checks the area and forms the cell address.
`timescale 1ns / 1ps

module fmms_front #(
   parameter int MAX_COLS = fmms_pkg::DEF_MAX_COLS,
   parameter int MAX_ROWS = fmms_pkg::DEF_MAX_ROWS
) (
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_command,
   input  logic signed [7:0]             req_col,
   input  logic signed [7:0]             req_row,
   input  logic signed [15:0]            req_cell_value,
   input  fmms_pkg::cfg_type             cfg,
   output logic                          push,
   output fmms_pkg::op_type              push_op,
   input  logic                          push_ready
);

   localparam int AW = fmms_pkg::ADDR_BITS;

   logic [6:0]    col_lim;
   logic [6:0]    row_lim;
   logic          in_area;
   logic [AW-1:0] addr;

   assign col_lim = (cfg.cols_in_use > 7'(MAX_COLS)) ? 7'(MAX_COLS) : cfg.cols_in_use;
   assign row_lim = (cfg.rows_in_use > 7'(MAX_ROWS)) ? 7'(MAX_ROWS) : cfg.rows_in_use;

   assign in_area = !req_col[7] && (req_col[6:0] < col_lim) &&
                    !req_row[7] && (req_row[6:0] < row_lim);

   assign addr = AW'(AW'(req_row[6:0]) * AW'(MAX_ROWS > 0 ? MAX_COLS : 1)) +
                 AW'(req_col[6:0]);

   always_comb begin
      push_op.addr  = addr;
      push_op.value = req_cell_value;
      if (req_command == fmms_pkg::CMD_WRITE) begin
         push_op.kind = in_area ? fmms_pkg::OP_WRITE : fmms_pkg::OP_WRITE_SKIP;
      end else begin
         push_op.kind = in_area ? fmms_pkg::OP_READ : fmms_pkg::OP_READ_SKIP;
      end
   end

   assign req_ready = push_ready;
   assign push      = req_valid && push_ready;

endmodule

### rtl/fmms_queue.sv
// Short item queue between the front end and the back end.
`timescale 1ns / 1ps

module fmms_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  fmms_pkg::op_type push_op,
   output logic             push_ready,
   output logic             pop_valid,
   output fmms_pkg::op_type pop_op,
   input  logic             pop
);

   localparam int DEPTH = fmms_pkg::QUEUE_DEPTH;
   localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW    = $clog2(DEPTH + 1);

   fmms_pkg::op_type entry_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff;
   logic [PW-1:0]    rd_ptr_ff;
   logic [CW-1:0]    count_ff;

   assign push_ready = (count_ff != CW'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_op     = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_op;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

### rtl/fmms_back.sv
// Back end: cell store, low/high marks, stretch multiply and serial divide.
`timescale 1ns / 1ps

module fmms_back #(
   parameter int MAX_COLS  = fmms_pkg::DEF_MAX_COLS,
   parameter int MAX_ROWS  = fmms_pkg::DEF_MAX_ROWS,
   parameter int CELL_BITS = fmms_pkg::DEF_CELL_BITS
) (
   input  logic                clock,
   input  logic                reset,
   input  fmms_pkg::cfg_type   cfg,
   input  logic                pop_valid,
   input  fmms_pkg::op_type    pop_op,
   output logic                pop,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic signed [31:0]  rsp_result_value,
   output logic                rsp_out_of_area
);

   localparam int DEPTH = MAX_COLS * MAX_ROWS;
   localparam int MW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int NUM_W = 16 + CELL_BITS;
   localparam int CNT_W = $clog2(NUM_W + 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SETUP,
      ST_MUL,
      ST_DIV,
      ST_DONE
   } state_type;

   state_type                    state_ff;
   logic signed [CELL_BITS-1:0]  mem [DEPTH];
   logic signed [CELL_BITS-1:0]  rd_data_ff;
   logic signed [CELL_BITS-1:0]  low_ff;
   logic signed [CELL_BITS-1:0]  high_ff;
   logic [CELL_BITS-1:0]         span_ff;
   logic [CELL_BITS-1:0]         diff_ff;
   logic [15:0]                  magd_ff;
   logic                         neg_ff;
   logic                         zero_span_ff;
   logic [NUM_W-1:0]             num_ff;
   logic [CELL_BITS-1:0]         rem_ff;
   logic [CNT_W-1:0]             cnt_ff;
   logic                         rsp_valid_ff;
   logic signed [31:0]           rsp_value_ff;
   logic                         rsp_oob_ff;

   logic                         out_free;
   logic                         rsp_load;
   logic                         mem_we;
   logic [MW-1:0]                mem_addr;
   logic signed [31:0]           value_ext;
   logic signed [CELL_BITS-1:0]  cell_sv;
   logic signed [CELL_BITS:0]    span_s;
   logic signed [CELL_BITS:0]    diff_s;
   logic signed [16:0]           range_s;
   logic [16:0]                  range_mag;
   logic [NUM_W-1:0]             prod;
   logic [CELL_BITS:0]           trial;
   logic                         trial_ge;
   logic signed [17:0]           quo_s;
   logic signed [18:0]           stretch_s;
   logic signed [31:0]           done_value;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign pop       = (state_ff == ST_IDLE) && pop_valid && out_free;
   assign rsp_load  = (pop && (pop_op.kind != fmms_pkg::OP_READ)) ||
                      ((state_ff == ST_DONE) && out_free);
   assign mem_we    = pop && (pop_op.kind == fmms_pkg::OP_WRITE);
   assign mem_addr  = pop_op.addr[MW-1:0];

   assign value_ext = 32'(pop_op.value);
   assign cell_sv   = value_ext[CELL_BITS-1:0];

   assign span_s    = {high_ff[CELL_BITS-1], high_ff} - {low_ff[CELL_BITS-1], low_ff};
   assign diff_s    = {rd_data_ff[CELL_BITS-1], rd_data_ff} - {low_ff[CELL_BITS-1], low_ff};
   assign range_s   = {cfg.out_max[15], cfg.out_max} - {cfg.out_min[15], cfg.out_min};
   assign range_mag = range_s[16] ? 17'(-range_s) : 17'(range_s);

   assign prod = {{CELL_BITS{1'b0}}, magd_ff} * {16'b0, diff_ff};

   assign trial    = {rem_ff, num_ff[NUM_W-1]};
   assign trial_ge = (trial >= {1'b0, span_ff});

   assign quo_s      = neg_ff ? -$signed({1'b0, num_ff[16:0]}) : $signed({1'b0, num_ff[16:0]});
   assign stretch_s  = 19'(quo_s) + 19'(cfg.out_min);
   assign done_value = zero_span_ff ? 32'(cfg.out_min) : 32'(stretch_s);

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_addr] <= cell_sv;
      end
      rd_data_ff <= mem[mem_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         low_ff       <= {1'b0, {(CELL_BITS - 1){1'b1}}};
         high_ff      <= {1'b1, {(CELL_BITS - 1){1'b0}}};
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_load || (rsp_valid_ff && !rsp_ready);
         case (state_ff)
            ST_IDLE: begin
               if (pop) begin
                  case (pop_op.kind)
                     fmms_pkg::OP_WRITE: begin
                        if (cell_sv < low_ff) begin
                           low_ff <= cell_sv;
                        end
                        if (cell_sv > high_ff) begin
                           high_ff <= cell_sv;
                        end
                        rsp_value_ff <= 32'(cell_sv);
                        rsp_oob_ff   <= 1'b0;
                     end
                     fmms_pkg::OP_WRITE_SKIP: begin
                        rsp_value_ff <= value_ext;
                        rsp_oob_ff   <= 1'b1;
                     end
                     fmms_pkg::OP_READ_SKIP: begin
                        rsp_value_ff <= 32'(cfg.outside_value);
                        rsp_oob_ff   <= 1'b1;
                     end
                     default: begin
                        state_ff <= ST_SETUP;
                     end
                  endcase
               end
            end
            ST_SETUP: begin
               span_ff      <= span_s[CELL_BITS-1:0];
               diff_ff      <= diff_s[CELL_BITS-1:0];
               magd_ff      <= range_mag[15:0];
               neg_ff       <= range_s[16];
               zero_span_ff <= (span_s == '0);
               state_ff     <= (span_s == '0) ? ST_DONE : ST_MUL;
            end
            ST_MUL: begin
               num_ff   <= prod;
               rem_ff   <= '0;
               cnt_ff   <= CNT_W'(NUM_W);
               state_ff <= ST_DIV;
            end
            ST_DIV: begin
               rem_ff <= trial_ge ? CELL_BITS'(trial - {1'b0, span_ff}) : trial[CELL_BITS-1:0];
               num_ff <= {num_ff[NUM_W-2:0], trial_ge};
               cnt_ff <= cnt_ff - 1'b1;
               if (cnt_ff == CNT_W'(1)) begin
                  state_ff <= ST_DONE;
               end
            end
            ST_DONE: begin
               if (out_free) begin
                  rsp_value_ff <= done_value;
                  rsp_oob_ff   <= 1'b0;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_value = rsp_value_ff;
   assign rsp_out_of_area  = rsp_oob_ff;

endmodule

### rtl/frame_store_min_max_stretch_top.sv
// Top level of the frame store with min/max contrast stretch.
//
// channel   direction  handshake            payload
// req       in         req_valid/req_ready  command, col, row, cell_value
// rsp       out        rsp_valid/rsp_ready  result_value, out_of_area
// csr       in         csr_wen              csr_index, csr_wdata
//
// A write or an outside-area read passes from the queue straight to the result
// register; an in-area read first runs through setup, multiply, one
// restoring-divider step per numerator bit and the final add (a zero span skips
// multiply and divide). The back end takes the next queued item only after that.
// The 2-entry queue lets the front accept items while the back end is busy.
// A result held by rsp_ready stalls the back end, then the queue, then req_ready.
// Synchronous active-high reset clears control, marks and config registers;
// cell contents are undefined until written.
`timescale 1ns / 1ps

module frame_store_min_max_stretch_top #(
   parameter int MAX_COLS  = fmms_pkg::DEF_MAX_COLS,
   parameter int MAX_ROWS  = fmms_pkg::DEF_MAX_ROWS,
   parameter int CELL_BITS = fmms_pkg::DEF_CELL_BITS
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_command,
   input  logic signed [7:0]  req_col,
   input  logic signed [7:0]  req_row,
   input  logic signed [15:0] req_cell_value,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_result_value,
   output logic               rsp_out_of_area,
   input  logic               csr_wen,
   input  logic [2:0]         csr_index,
   input  logic [15:0]        csr_wdata
);

   fmms_pkg::cfg_type cfg_ff;
   logic              push;
   logic              push_ready;
   fmms_pkg::op_type  push_op;
   logic              pop;
   logic              pop_valid;
   fmms_pkg::op_type  pop_op;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.cols_in_use   <= fmms_pkg::RST_COLS_IN_USE;
         cfg_ff.rows_in_use   <= fmms_pkg::RST_ROWS_IN_USE;
         cfg_ff.out_min       <= fmms_pkg::RST_OUT_MIN;
         cfg_ff.out_max       <= fmms_pkg::RST_OUT_MAX;
         cfg_ff.outside_value <= fmms_pkg::RST_OUTSIDE_VALUE;
      end else if (csr_wen) begin
         case (csr_index)
            fmms_pkg::REG_COLS_IN_USE:   cfg_ff.cols_in_use   <= csr_wdata[6:0];
            fmms_pkg::REG_ROWS_IN_USE:   cfg_ff.rows_in_use   <= csr_wdata[6:0];
            fmms_pkg::REG_OUT_MIN:       cfg_ff.out_min       <= csr_wdata;
            fmms_pkg::REG_OUT_MAX:       cfg_ff.out_max       <= csr_wdata;
            fmms_pkg::REG_OUTSIDE_VALUE: cfg_ff.outside_value <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   fmms_front #(
      .MAX_COLS (MAX_COLS),
      .MAX_ROWS (MAX_ROWS)
   ) u_front (
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_command    (req_command),
      .req_col        (req_col),
      .req_row        (req_row),
      .req_cell_value (req_cell_value),
      .cfg            (cfg_ff),
      .push           (push),
      .push_op        (push_op),
      .push_ready     (push_ready)
   );

   fmms_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_op    (push_op),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_op     (pop_op),
      .pop        (pop)
   );

   fmms_back #(
      .MAX_COLS  (MAX_COLS),
      .MAX_ROWS  (MAX_ROWS),
      .CELL_BITS (CELL_BITS)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .pop_valid        (pop_valid),
      .pop_op           (pop_op),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_result_value (rsp_result_value),
      .rsp_out_of_area  (rsp_out_of_area)
   );

endmodule
